// File: src/rmx_pkg.sv
// Shared constants for the RSA modular exponentiation block.
// Register indexes, operation codes, status codes and fixed field widths; no dependencies.
package rmx_pkg;

  localparam int DATA_WIDTH    = 64;
  localparam int EXP_WIDTH     = 64;
  localparam int EXP_CNT_WIDTH = $clog2(EXP_WIDTH);
  localparam int CFG_IDX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

// File: src/rmx_mulmod.sv
// Shift-add modular multiplier: (a * b) mod n, one bit of b per cycle.
// Shared unit used for every square and multiply; uses rmx_pkg.
module rmx_mulmod import rmx_pkg::*; #(
  parameter int MOD_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] n,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] result
);

  localparam int CW = $clog2(MOD_WIDTH + 1);
  localparam int TW = MOD_WIDTH + 2;

  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] b_r;
  logic [MOD_WIDTH-1:0] n_r;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] acc_next;
  logic [CW-1:0]        cnt;
  logic                 busy;

  logic [TW-1:0] sum;
  logic [TW-1:0] n1;
  logic [TW-1:0] n2;
  logic [TW-1:0] sel;

  // double the accumulator, add a if the current bit is set, reduce by n or 2n
  always_comb begin
    n1  = TW'(n_r);
    n2  = n1 << 1;
    sum = TW'({acc, 1'b0}) + (b_r[MOD_WIDTH-1] ? TW'(a_r) : '0);
    if (sum >= n2) begin
      sel = sum - n2;
    end else if (sum >= n1) begin
      sel = sum - n1;
    end else begin
      sel = sum;
    end
    acc_next = sel[MOD_WIDTH-1:0];
  end

  // control: load on start, count down the bits of b
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MOD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      n_r <= n;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= b_r << 1;
    end
  end

  assign result = acc;

endmodule

// File: src/rsa_modexp_primitive_unit.sv
// RSA modular exponentiation, square-and-multiply over all 64 exponent bits.
// Each exponent bit takes a square, plus a multiply when the bit is set, on the shared shift-add
// multiplier, which handles one bit of its operand per cycle. An out-of-range value skips the
// multiplier and goes straight to the finish state. One item at a time: in_stall
// is high until the result is in the output register. Reset (rst, synchronous) clears the
// key registers to 0, idles the sequencer and drops out_valid. Uses rmx_pkg and rmx_mulmod.
module rsa_modexp_primitive_unit import rmx_pkg::*; #(
  parameter int MOD_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic [DATA_WIDTH-1:0]    value_in,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_WIDTH-1:0]    value_out,
  output logic                     status,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SQ_START = 3'd1;
  localparam logic [2:0] ST_SQ_WAIT  = 3'd2;
  localparam logic [2:0] ST_MU_START = 3'd3;
  localparam logic [2:0] ST_MU_WAIT  = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  logic [MOD_WIDTH-1:0]     modulus;
  logic [EXP_WIDTH-1:0]     public_exponent;
  logic [EXP_WIDTH-1:0]     private_exponent;

  logic [2:0]               state;
  logic [MOD_WIDTH-1:0]     acc;
  logic [MOD_WIDTH-1:0]     base;
  logic [EXP_WIDTH-1:0]     exp_sh;
  logic [EXP_CNT_WIDTH-1:0] bit_cnt;
  logic                     reject;

  logic                     mm_start;
  logic                     mm_done;
  logic [MOD_WIDTH-1:0]     mm_b;
  logic [MOD_WIDTH-1:0]     mm_result;
  logic                     in_fire;
  logic                     out_free;
  logic                     last_bit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_bit  = (bit_cnt == EXP_CNT_WIDTH'(EXP_WIDTH - 1));
  assign mm_start  = (state == ST_SQ_START) || (state == ST_MU_START);
  assign mm_b      = (state == ST_MU_START) ? base : acc;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= '0;
      public_exponent  <= '0;
      private_exponent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS:          modulus          <= cfg_data[MOD_WIDTH-1:0];
        REG_PUBLIC_EXPONENT:  public_exponent  <= cfg_data;
        REG_PRIVATE_EXPONENT: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  rmx_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (acc),
    .b      (mm_b),
    .n      (modulus),
    .done   (mm_done),
    .result (mm_result)
  );

  // sequencer: square every exponent bit, multiply when the bit is set
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (value_in >= DATA_WIDTH'(modulus)) ? ST_FINISH : ST_SQ_START;
          end
        end
        ST_SQ_START: state <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (mm_done) begin
            if (exp_sh[EXP_WIDTH-1]) begin
              state <= ST_MU_START;
            end else begin
              state <= last_bit ? ST_FINISH : ST_SQ_START;
            end
          end
        end
        ST_MU_START: state <= ST_MU_WAIT;
        ST_MU_WAIT: begin
          if (mm_done) begin
            state <= last_bit ? ST_FINISH : ST_SQ_START;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      reject  <= (value_in >= DATA_WIDTH'(modulus));
      base    <= value_in[MOD_WIDTH-1:0];
      acc     <= (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
      exp_sh  <= (op == OP_DECRYPT) ? private_exponent : public_exponent;
      bit_cnt <= '0;
    end else if (mm_done) begin
      acc <= mm_result;
      // advance to the next exponent bit once its square, and its multiply if the bit is set, are in
      if ((state == ST_MU_WAIT) || !exp_sh[EXP_WIDTH-1]) begin
        exp_sh  <= exp_sh << 1;
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      value_out <= reject ? '0 : DATA_WIDTH'(acc);
      status    <= reject ? STATUS_RANGE : STATUS_OK;
    end
  end

endmodule

// File: src/rmx_checker.sv
// Port-level checks for rsa_modexp_primitive_unit, attached by bind.
// Depends on rmx_pkg for field widths and status codes.
module rmx_checker import rmx_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [DATA_WIDTH-1:0]    value_out,
  input logic                     status
);

  // drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status))
    else $error("stalled result changed");

  // a rejected value always reads as zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_RANGE) |-> value_out == '0)
    else $error("range error with nonzero value");

  // one item at a time: input stalls right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

endmodule

bind rsa_modexp_primitive_unit rmx_checker u_rmx_checker (.*);
